// ===== hdl/crlf_line_setting_parser_defines.svh =====
// Assertion macros for the CR/LF line setting parser.
`ifndef CRLF_LINE_SETTING_PARSER_DEFINES_SVH
`define CRLF_LINE_SETTING_PARSER_DEFINES_SVH

// Same-cycle implication, checked on i_clk, off while reset is low.
`define CLSP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk, off while reset is low.
`define CLSP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/clsp_pkg.sv =====
// Constants shared by the CR/LF line setting parser.
`timescale 1ns / 1ps
package clsp_pkg;

    localparam int TGT_W = 3;
    localparam int VAL_W = 17;

    // Tail window: enough bytes back from the line end to hold NN=iii.ff
    localparam int WIN   = 9;
    localparam int WK_W  = 4;

    localparam logic [7:0] BYTE_CR = 8'h0d;
    localparam logic [7:0] BYTE_LF = 8'h0a;
    localparam logic [7:0] CH_DOT  = 8'h2e;
    localparam logic [7:0] CH_EQ   = 8'h3d;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_K    = 8'h4b;
    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_I    = 8'h49;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_V    = 8'h56;
    localparam logic [7:0] CH_G    = 8'h47;
    localparam logic [7:0] CH_L    = 8'h4c;

    localparam logic [TGT_W-1:0] TGT_KP        = 3'd0;
    localparam logic [TGT_W-1:0] TGT_KI        = 3'd1;
    localparam logic [TGT_W-1:0] TGT_KD        = 3'd2;
    localparam logic [TGT_W-1:0] TGT_SV        = 3'd3;
    localparam logic [TGT_W-1:0] TGT_GL        = 3'd4;
    localparam logic [TGT_W-1:0] TGT_UNKNOWN   = 3'd5;
    localparam logic [TGT_W-1:0] TGT_MALFORMED = 3'd6;

endpackage

// ===== hdl/crlf_line_setting_parser.sv =====
// CR/LF line setting parser: line buffer memory, tail read-back and NN=iii.ff decode.
//
//  channel | direction | handshake                  | payload
//  rx      | in        | i_rx_valid / o_rx_stall    | i_rx_byte
//  res     | out       | o_res_valid / i_res_stall  | o_target, o_value_hundredths
//
// Any byte other than an LF after CR is taken without stalling the input.
// An LF after CR stalls the input through ST_READ, ST_EVAL and ST_DONE, in which the last
// min(n, 9) bytes of an n-byte line are read back, decoded and loaded into the result register.
// The tail is read back one byte a cycle, then decoded in two steps.
// Reset (synchronous, active low) clears the fill count, the CR flag and the result slot.
// The parse waits in its last step while the result register is full and stalled.
`timescale 1ns / 1ps
`include "crlf_line_setting_parser_defines.svh"
module crlf_line_setting_parser #(
    parameter int LINE_MAX = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rx_valid,
    output logic                        o_rx_stall,
    input  logic [7:0]                  i_rx_byte,
    output logic                        o_res_valid,
    input  logic                        i_res_stall,
    output logic [clsp_pkg::TGT_W-1:0]  o_target,
    output logic [clsp_pkg::VAL_W-1:0]  o_value_hundredths
);
    import clsp_pkg::*;

    localparam int FW = $clog2(LINE_MAX);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_EVAL = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [FW-1:0]     r_fill, n_fill;
    logic              r_seen_cr, n_seen_cr;
    logic [WK_W-1:0]   r_m, n_m;
    logic [WK_W-1:0]   r_rd_k, n_rd_k;
    logic              r_cap_en;
    logic [WK_W-1:0]   r_cap_k;
    logic [7:0]        r_rd_data;
    logic [7:0]        r_win [WIN];
    logic [7:0]        r_line_buf [LINE_MAX];

    logic              r_bad;
    logic [TGT_W-1:0]  r_tgt;
    logic [9:0]        r_ip;
    logic [6:0]        r_fp;

    logic              r_res_valid;
    logic [TGT_W-1:0]  r_res_tgt;
    logic [VAL_W-1:0]  r_res_val;

    logic              rx_acc;
    logic              wr_en;
    logic              lf_go;
    logic              out_free;
    logic              rd_issue;
    logic [FW-1:0]     rd_addr;

    assign o_rx_stall = (r_state != ST_IDLE);
    assign rx_acc     = i_rx_valid && !o_rx_stall;
    assign wr_en      = rx_acc && !r_seen_cr && (i_rx_byte != BYTE_CR);
    assign lf_go      = rx_acc && r_seen_cr && (i_rx_byte == BYTE_LF);
    assign out_free   = !r_res_valid || !i_res_stall;
    assign rd_issue   = (r_state == ST_READ) && (r_rd_k != r_m);
    assign rd_addr    = r_fill - FW'(1) - FW'(r_rd_k);

    // Control next state
    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_seen_cr = r_seen_cr;
        n_m       = r_m;
        n_rd_k    = r_rd_k;
        case (r_state)
            ST_IDLE: begin
                if (rx_acc) begin
                    if (r_seen_cr) begin
                        n_seen_cr = 1'b0;
                        if (i_rx_byte == BYTE_LF) begin
                            n_state = ST_READ;
                            n_rd_k  = '0;
                            n_m     = (32'(r_fill) < WIN) ? WK_W'(r_fill) : WK_W'(WIN);
                        end else begin
                            n_fill = '0;
                        end
                    end else if (i_rx_byte == BYTE_CR) begin
                        n_seen_cr = 1'b1;
                    end else begin
                        // drop the line when it would reach the buffer size
                        n_fill = (r_fill == FW'(LINE_MAX - 1)) ? '0 : r_fill + 1'b1;
                    end
                end
            end
            ST_READ: begin
                if (r_rd_k == r_m) begin
                    n_state = ST_EVAL;
                    n_fill  = '0;
                end else begin
                    n_rd_k = r_rd_k + 1'b1;
                end
            end
            ST_EVAL: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= '0;
            r_seen_cr <= 1'b0;
            r_m       <= '0;
            r_rd_k    <= '0;
            r_cap_en  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_seen_cr <= n_seen_cr;
            r_m       <= n_m;
            r_rd_k    <= n_rd_k;
            r_cap_en  <= rd_issue;
        end
    end

    // Line buffer: written while idle and read every cycle; the read data is kept only during ST_READ
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_line_buf[r_fill] <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_line_buf[rd_addr];
        r_cap_k   <= r_rd_k;
    end

    // Tail window, entry k holds the byte k places before the line end
    always_ff @(posedge i_clk) begin
        if (r_cap_en) begin
            r_win[r_cap_k] <= r_rd_data;
        end
    end

    // Decode of the tail window
    logic [WIN-1:0]   wv, is_dig, is_dot, is_eq;
    logic [3:0]       dig [WIN];
    logic             bad, found;
    logic [1:0]       dk;
    logic [2:0]       eqo;
    logic [WK_W-1:0]  j, p1, p2, p3;
    logic [7:0]       c_first, c_second;
    logic [9:0]       ip;
    logic [6:0]       fp;
    logic [TGT_W-1:0] tgt;

    always_comb begin
        for (int k = 0; k < WIN; k++) begin
            wv[k]     = WK_W'(k) < r_m;
            is_dig[k] = wv[k] && (r_win[k] >= CH_0) && (r_win[k] <= CH_9);
            is_dot[k] = wv[k] && (r_win[k] == CH_DOT);
            is_eq[k]  = wv[k] && (r_win[k] == CH_EQ);
            dig[k]    = r_win[k][3:0];
        end

        // last dot must leave one or two fraction digits
        bad = 1'b0;
        dk  = 2'd0;
        if (is_dot[0]) begin
            bad = 1'b1;
        end else if (is_dot[1]) begin
            dk = 2'd1;
        end else if (is_dot[2]) begin
            dk = 2'd2;
        end else begin
            bad = 1'b1;
        end

        // nearest '=' before the dot, within reach of three integer digits
        found = 1'b0;
        eqo   = 3'd0;
        for (int o = 1; o <= 4; o++) begin
            if (!found && is_eq[WK_W'(dk) + WK_W'(o)]) begin
                found = 1'b1;
                eqo   = 3'(o);
            end
        end
        if (!found || (eqo == 3'd1)) begin
            bad = 1'b1;
        end

        j  = WK_W'(dk) + WK_W'(eqo);
        p1 = WK_W'(dk) + WK_W'(1);
        p2 = WK_W'(dk) + WK_W'(2);
        p3 = WK_W'(dk) + WK_W'(3);

        // two name characters must precede '='
        if (!wv[j + WK_W'(2)]) begin
            bad = 1'b1;
        end
        for (int k = 0; k < WIN; k++) begin
            if ((WK_W'(k) < j) && (WK_W'(k) != WK_W'(dk)) && !is_dig[k]) begin
                bad = 1'b1;
            end
        end

        ip = 10'(dig[p1])
           + ((eqo >= 3'd3) ? 10'(dig[p2]) * 10'd10 : 10'd0)
           + ((eqo == 3'd4) ? 10'(dig[p3]) * 10'd100 : 10'd0);
        fp = (dk == 2'd2) ? 7'(dig[1]) * 7'd10 + 7'(dig[0]) : 7'(dig[0]) * 7'd10;

        c_second = r_win[j + WK_W'(1)];
        c_first  = r_win[j + WK_W'(2)];
        if (c_first == CH_K && c_second == CH_P) begin
            tgt = TGT_KP;
        end else if (c_first == CH_K && c_second == CH_I) begin
            tgt = TGT_KI;
        end else if (c_first == CH_K && c_second == CH_D) begin
            tgt = TGT_KD;
        end else if (c_first == CH_S && c_second == CH_V) begin
            tgt = TGT_SV;
        end else if (c_first == CH_G && c_second == CH_L) begin
            tgt = TGT_GL;
        end else begin
            tgt = TGT_UNKNOWN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EVAL) begin
            r_bad <= bad;
            r_tgt <= tgt;
            r_ip  <= ip;
            r_fp  <= fp;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && out_free) begin
            r_res_valid <= 1'b1;
        end else if (r_res_valid && !i_res_stall) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && out_free) begin
            r_res_tgt <= r_bad ? TGT_MALFORMED : r_tgt;
            r_res_val <= r_bad ? '0 : VAL_W'(r_ip) * VAL_W'(100) + VAL_W'(r_fp);
        end
    end

    assign o_res_valid        = r_res_valid;
    assign o_target           = r_res_tgt;
    assign o_value_hundredths = r_res_val;

    `CLSP_ASSERT_IMP(a_res_from_done, $rose(o_res_valid), $past(r_state) == ST_DONE, "stray result")
    `CLSP_ASSERT_IMP(a_mal_zero, o_target == TGT_MALFORMED, o_value_hundredths == '0, "nonzero")
    `CLSP_ASSERT_IMP(a_fill_bound, 1'b1, 32'(r_fill) < LINE_MAX, "fill count out of range")
    `CLSP_ASSERT_NXT(a_lf_starts_read, lf_go, (r_state == ST_READ) && (r_rd_k == '0), "no read")

endmodule

// ===== sim/crlf_line_setting_parser_tb.sv =====
// Self-checking testbench for the CR/LF line setting parser.
`timescale 1ns / 1ps
module crlf_line_setting_parser_tb;
    import clsp_pkg::*;

    localparam int LINE_MAX        = 256;
    localparam int HOLD_CYCLES     = 600;
    localparam int WATCHDOG_CYCLES = 5000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int PHASE_BYTES     = 250;

    typedef struct packed {
        logic [TGT_W-1:0] target;
        logic [VAL_W-1:0] value;
    } t_setting;

    // Tracks the line in progress and holds the settings still to come out.
    class setting_board;
        logic [7:0] line_mem [LINE_MAX];
        int         fill;
        bit         cr_seen;
        t_setting   due_q[$];
        int         fails;

        function new();
            fill    = 0;
            cr_seen = 1'b0;
            fails   = 0;
        endfunction

        // Accumulate decimal digits in [lo, hi); flag any non-digit.
        function bit digits_value(int lo, int hi, output int v);
            v = 0;
            for (int i = lo; i < hi; i++) begin
                if (line_mem[i] < CH_0 || line_mem[i] > CH_9) return 1'b0;
                v = v * 10 + int'(line_mem[i] - CH_0);
            end
            return 1'b1;
        endfunction

        function t_setting decode_line(int n);
            t_setting r;
            int       dot, eq, ival, fval, flen, ilen;
            r.target = TGT_MALFORMED;
            r.value  = '0;
            dot = -1;
            for (int i = n - 1; i >= 0; i--) begin
                if (line_mem[i] == CH_DOT) begin
                    dot = i;
                    break;
                end
            end
            if (dot < 0) return r;
            flen = n - 1 - dot;
            if (flen < 1 || flen > 2) return r;
            eq = -1;
            for (int i = dot - 1; i >= 0; i--) begin
                if (line_mem[i] == CH_EQ) begin
                    eq = i;
                    break;
                end
            end
            if (eq < 2) return r;
            ilen = dot - eq - 1;
            if (ilen < 1 || ilen > 3) return r;
            if (!digits_value(eq + 1, dot, ival)) return r;
            if (!digits_value(dot + 1, n, fval)) return r;
            if (flen == 1) fval = fval * 10;
            case ({line_mem[eq - 2], line_mem[eq - 1]})
                {CH_K, CH_P}: r.target = TGT_KP;
                {CH_K, CH_I}: r.target = TGT_KI;
                {CH_K, CH_D}: r.target = TGT_KD;
                {CH_S, CH_V}: r.target = TGT_SV;
                {CH_G, CH_L}: r.target = TGT_GL;
                default:      r.target = TGT_UNKNOWN;
            endcase
            r.value = VAL_W'(ival * 100 + fval);
            return r;
        endfunction

        function void take_byte(logic [7:0] ch);
            if (cr_seen) begin
                if (ch == BYTE_LF) due_q.push_back(decode_line(fill));
                fill    = 0;
                cr_seen = 1'b0;
            end else if (ch == BYTE_CR) begin
                cr_seen = 1'b1;
            end else begin
                line_mem[fill] = ch;
                fill++;
                // drop the line on overflow
                if (fill >= LINE_MAX) fill = 0;
            end
        endfunction

        function void check_setting(logic [TGT_W-1:0] tgt, logic [VAL_W-1:0] val);
            t_setting want;
            if (due_q.size() == 0) begin
                $error("unexpected result: target %0d value_hundredths %0d", tgt, val);
                fails++;
                return;
            end
            want = due_q.pop_front();
            if (tgt !== want.target) begin
                $error("target: expected %0d, actual %0d", want.target, tgt);
                fails++;
            end
            if (val !== want.value) begin
                $error("value_hundredths: expected %0d, actual %0d", want.value, val);
                fails++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_rx_valid;
    logic               o_rx_stall;
    logic [7:0]         i_rx_byte;
    logic               o_res_valid;
    logic               i_res_stall;
    logic [TGT_W-1:0]   o_target;
    logic [VAL_W-1:0]   o_value_hundredths;

    setting_board board = new();
    int send_idle_pct = 28;
    int recv_idle_pct = 74;
    bit hold_go       = 1'b0;
    int quiet_cycles  = 0;

    crlf_line_setting_parser #(
        .LINE_MAX(LINE_MAX)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_rx_valid        (i_rx_valid),
        .o_rx_stall        (o_rx_stall),
        .i_rx_byte         (i_rx_byte),
        .o_res_valid       (o_res_valid),
        .i_res_stall       (i_res_stall),
        .o_target          (o_target),
        .o_value_hundredths(o_value_hundredths)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_rx_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_rx_stall) @(posedge i_clk);
        board.take_byte(b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_line(input string s);
        send_text(s);
        send_byte(BYTE_CR);
        send_byte(BYTE_LF);
    endtask

    task automatic run_directed();
        string lines[] = '{"", "KP=0.0", "KI=999.99", "KD=5.5", "SV=12.34", "GL=7.01",
                           "ab=3.25", "kp=1.5", "KP=1.2.34", "A=KI=45.6", "##KD=1.5",
                           "KP=1234.5", "KP=.5", "KP=1.234", "KP=1.", "KP15", "KP1.5",
                           "P=1.5", "KP=1a.5", "KP=1.b"};
        foreach (lines[i]) send_line(lines[i]);
        send_byte(8'h00);
        send_byte(8'hff);
        send_line("KD=1.5");
        // CR followed by a non-LF byte drops the line
        send_text("KP=2.5");
        send_byte(BYTE_CR);
        send_byte("x");
        send_line("KI=3.5");
        send_text("GL=4.4");
        send_byte(BYTE_CR);
        send_byte(BYTE_CR);
        send_line("SV=0.01");
        // longest line that is still held, then one that overflows
        repeat (LINE_MAX - 7) send_byte("z");
        send_line("KP=9.9");
        repeat (LINE_MAX) send_byte("q");
        send_line("SV=1.1");
    endtask

    function automatic logic [7:0] rand_digit();
        return CH_0 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_print();
        return 8'($urandom_range(8'h20, 8'h7e));
    endfunction

    function automatic int odd_len(int lo, int hi);
        if ($urandom_range(0, 99) < 94) return $urandom_range(lo, hi);
        return $urandom_range(0, 1) ? lo - 1 : hi + 1;
    endfunction

    // Mostly well-formed settings with random content; some noise and broken lines.
    function automatic void compose_line(ref logic [7:0] q[$]);
        int         pick, pad, t;
        logic [7:0] b;
        q.delete();
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 149) == 0) pad = $urandom_range(230, 300);
        else if ($urandom_range(0, 9) == 0) pad = $urandom_range(1, 6);
        else pad = 0;
        repeat (pad) begin
            b = 8'($urandom_range(0, 255));
            if (b == BYTE_CR) b = CH_DOT;
            q.push_back(b);
        end
        case ($urandom_range(0, 7))
            0: begin q.push_back(CH_K); q.push_back(CH_P); end
            1: begin q.push_back(CH_K); q.push_back(CH_I); end
            2: begin q.push_back(CH_K); q.push_back(CH_D); end
            3: begin q.push_back(CH_S); q.push_back(CH_V); end
            4: begin q.push_back(CH_G); q.push_back(CH_L); end
            5: begin q.push_back(rand_print()); q.push_back(rand_print()); end
            6: begin q.push_back(CH_K); q.push_back(rand_print()); end
            default: if ($urandom_range(0, 1)) q.push_back(rand_print());
        endcase
        if ($urandom_range(0, 99) >= 3) q.push_back(CH_EQ);
        repeat (odd_len(1, 3)) q.push_back(rand_digit());
        if ($urandom_range(0, 99) >= 3) q.push_back(CH_DOT);
        repeat (odd_len(1, 2)) q.push_back(rand_digit());
        if ($urandom_range(0, 9) == 0 && q.size() > 0)
            q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
        t = $urandom_range(0, 99);
        if (t < 86) begin
            q.push_back(BYTE_CR);
            q.push_back(BYTE_LF);
        end else if (t < 93) begin
            b = 8'($urandom_range(0, 255));
            if (b == BYTE_LF) b = CH_K;
            q.push_back(BYTE_CR);
            q.push_back(b);
        end else if (t >= 97) begin
            q.push_back(BYTE_CR);
            q.push_back(BYTE_CR);
            q.push_back(BYTE_LF);
        end
    endfunction

    task automatic random_phase(input int want_bytes);
        logic [7:0] q[$];
        int         sent;
        sent = 0;
        while (sent < want_bytes) begin
            compose_line(q);
            foreach (q[i]) send_byte(q[i]);
            sent += q.size();
        end
    endtask

    // Result side: random stalls plus one long hold-off, counted here.
    initial begin
        int hold_left;
        bit hold_done;
        hold_left   = 0;
        hold_done   = 1'b0;
        i_res_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_res_stall <= 1'b1;
            end else begin
                i_res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && !i_res_stall)
            board.check_setting(o_target, o_value_hundredths);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_rx_valid && !o_rx_stall) || (o_res_valid && !i_res_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_rx_valid = 1'b0;
        i_rx_byte  = 8'h00;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        random_phase(PHASE_BYTES);
        send_idle_pct = 74;
        recv_idle_pct = 28;
        random_phase(PHASE_BYTES);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_go       = 1'b1;
        random_phase(PHASE_BYTES);
        @(negedge i_clk);
        i_rx_valid <= 1'b0;
        while (board.due_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.fails == 0 && board.due_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/clsp_pkg.sv
hdl/crlf_line_setting_parser.sv
sim/crlf_line_setting_parser_tb.sv
